// ===== hw/rtl/fpvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpvm_pkg;

	// n * numerator plus carried remainder: 4 x 16 bit product plus 16 bits
	localparam int DVD_W = 21;
	localparam int CNT_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 2'd2;

	localparam logic [15:0] NUMERATOR_RST = 16'd20;
	localparam logic [15:0] DENOMINATOR_RST = 16'd9;
	localparam logic [15:0] STALL_TIMEOUT_RST = 16'd3000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpvm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fpvm_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] new_pulses;
	logic       valve_level;
	logic       clear_meter;

	modport source (output valid, output new_pulses, output valve_level, output clear_meter,
		input ready);
	modport sink (input valid, input new_pulses, input valve_level, input clear_meter,
		output ready);
endinterface

interface fpvm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] volume_ml;
	logic [31:0] pulse_total;
	logic        stalled;

	modport source (output valid, output volume_ml, output pulse_total, output stalled,
		input ready);
	modport sink (input valid, input volume_ml, input pulse_total, input stalled,
		output ready);
endinterface

interface fpvm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fpvm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpvm_div
	import fpvm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [15:0]      divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient,
	output logic [15:0]           remainder
);

	logic [DVD_W-1:0] dvd_q;
	logic [15:0]      rem_q;
	logic [15:0]      den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [16:0]      trial;
	logic [16:0]      diff;
	logic             fits;

	// one quotient bit a cycle: shift the next dividend bit into the partial remainder
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			// quotient bits fill the dividend register from the bottom
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/flow_pulse_volume_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow pulse volume meter: one sample beat per millisecond tick, one result beat per sample.
// A tick without pulses goes from the calculate state straight to the done state; a tick
// with pulses passes through the divide state, where the bit-serial divider produces one
// of its 21 quotient bits a cycle. In the done state the result register is loaded once no
// earlier result is pending or it is being taken. A new sample can be taken in the cycle after
// that load, even while its result still waits to be taken. Configuration writes are always ready.
module flow_pulse_volume_meter
	import fpvm_pkg::*;
#(
	parameter int MAX_PULSES_PER_TICK = 15
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fpvm_in_if.sink   sample,
	fpvm_out_if.source result,
	fpvm_cfg_if.sink  cfg
);

	logic [15:0] num_q;
	logic [15:0] den_q;
	logic [15:0] timeout_q;

	logic [31:0] pulse_count_q;
	logic [15:0] volume_sum_q;
	logic [15:0] remainder_q;
	logic [15:0] idle_ms_q;
	logic        valve_was_open_q;

	logic [3:0]  n_q;
	logic        valve_q;
	logic        restart_q;

	logic        out_valid_q;
	logic [15:0] out_volume_q;
	logic [31:0] out_pulses_q;
	logic        out_stalled_q;

	state_t state_q;
	state_t state_d;

	logic             sample_ready;
	logic             div_start;
	logic             out_load;
	logic             accept;
	logic [3:0]       n_sat;
	logic [15:0]      den_eff;
	logic [DVD_W-1:0] scaled;
	logic             div_done;
	logic [DVD_W-1:0] div_quot;
	logic [15:0]      div_rem;
	logic [DVD_W:0]   vol_sum;
	logic [15:0]      idle_next;
	logic             restart;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q     <= NUMERATOR_RST;
			den_q     <= DENOMINATOR_RST;
			timeout_q <= STALL_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_NUMERATOR:     num_q     <= cfg.data;
				CFG_DENOMINATOR:   den_q     <= cfg.data;
				CFG_STALL_TIMEOUT: timeout_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign accept = sample.valid && sample_ready;

	always_comb begin
		if (32'(sample.new_pulses) > MAX_PULSES_PER_TICK) begin
			n_sat = 4'(MAX_PULSES_PER_TICK);
		end else begin
			n_sat = sample.new_pulses;
		end
	end

	assign den_eff = (den_q == 16'd0) ? 16'd1 : den_q;
	assign scaled  = DVD_W'(n_q) * DVD_W'(num_q) + DVD_W'(remainder_q);

	fpvm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (scaled),
		.divisor   (den_eff),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign vol_sum   = (DVD_W + 1)'(volume_sum_q) + (DVD_W + 1)'(div_quot);
	assign restart   = restart_q || (n_q != 4'd0);
	assign idle_next = restart ? 16'd0 :
		((idle_ms_q == 16'hFFFF) ? idle_ms_q : idle_ms_q + 16'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_CALC;
			ST_CALC: state_d = (n_q != 4'd0) ? ST_DIV : ST_DONE;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: sample_ready = 1'b1;
			ST_CALC: div_start = (n_q != 4'd0);
			ST_DIV:  ;
			ST_DONE: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign sample.ready = sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			pulse_count_q    <= '0;
			volume_sum_q     <= '0;
			remainder_q      <= '0;
			idle_ms_q        <= '0;
			valve_was_open_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// clear before the tick is worked; the valve history survives it
				if (sample.clear_meter) begin
					pulse_count_q <= '0;
					volume_sum_q  <= '0;
					remainder_q   <= '0;
					idle_ms_q     <= '0;
				end
				valve_was_open_q <= sample.valve_level;
			end
			if (state_q == ST_DIV && div_done) begin
				pulse_count_q <= pulse_count_q + 32'(n_q);
				volume_sum_q  <= (vol_sum > (DVD_W + 1)'(16'hFFFF)) ? 16'hFFFF : vol_sum[15:0];
				remainder_q   <= div_rem;
			end
			if (out_load) begin
				idle_ms_q   <= idle_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q       <= n_sat;
			valve_q   <= sample.valve_level;
			restart_q <= sample.valve_level && !valve_was_open_q;
		end
		if (out_load) begin
			out_volume_q  <= volume_sum_q;
			out_pulses_q  <= pulse_count_q;
			out_stalled_q <= valve_q && (idle_next >= timeout_q);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.volume_ml   = out_volume_q;
	assign result.pulse_total = out_pulses_q;
	assign result.stalled     = out_stalled_q;

endmodule

`default_nettype wire
